// ===== rtl/cnva_pkg.sv =====
// shared constants for the cell-to-node volume averaging block
package cnva_pkg;

  // grid limits
  localparam int unsigned MAX_X = 256;
  localparam int unsigned MAX_Y = 256;
  localparam int unsigned MAX_Z = 256;

  // position and size widths
  localparam int unsigned X_W    = $clog2(MAX_X);
  localparam int unsigned Y_W    = $clog2(MAX_Y);
  localparam int unsigned Z_W    = $clog2(MAX_Z);
  localparam int unsigned SIZE_W = 9;
  localparam int unsigned ADDR_W = X_W + Y_W;

  // payload widths
  localparam int unsigned VOL_W  = 32;
  localparam int unsigned PAIR_W = VOL_W + 1;
  localparam int unsigned QUAD_W = VOL_W + 2;
  localparam int unsigned OCT_W  = VOL_W + 3;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SIZE_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 2'd3;

  // register reset values
  localparam logic [1:0]        NUM_DIMS_RST = 2'd3;
  localparam logic [SIZE_W-1:0] SIZE_X_RST   = SIZE_W'(MAX_X);
  localparam logic [SIZE_W-1:0] SIZE_Y_RST   = SIZE_W'(MAX_Y);
  localparam logic [SIZE_W-1:0] SIZE_Z_RST   = SIZE_W'(MAX_Z);

  // limit a size register to 1 .. max
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > maxv) begin
      r = maxv;
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// ===== rtl/cell_to_node_volume_average.sv =====
// cell-to-node volume averaging over a raster-ordered grid, 2x2x2 box
// The result beat passes through the input register, loaded at accept, and
// the result register, loaded when the input register advances.
// Throughput: one beat per cycle unless the output stalls; the row and plane
// sum buffers are each read once at accept and written once when the item leaves the input register.
// Reset: clears grid position, handshake state and registers to defaults; the
// sum buffers are not cleared (no clearing pass), only read where written.
module cell_to_node_volume_average (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [cnva_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cnva_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cnva_pkg::VOL_W-1:0]          cell_volume,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cnva_pkg::VOL_W-1:0]          point_volume,
  output logic                                end_of_grid
);
  import cnva_pkg::*;

  // configuration registers
  logic [1:0]        num_dims;
  logic [SIZE_W-1:0] size_x;
  logic [SIZE_W-1:0] size_y;
  logic [SIZE_W-1:0] size_z;

  // grid position of the next beat
  logic [X_W-1:0] x_pos;
  logic [Y_W-1:0] y_pos;
  logic [Z_W-1:0] z_pos;

  // sum buffers
  logic [PAIR_W-1:0] row_mem   [MAX_X];
  logic [QUAD_W-1:0] plane_mem [MAX_X*MAX_Y];
  logic [PAIR_W-1:0] row_rd;
  logic [QUAD_W-1:0] plane_rd;
  logic [VOL_W-1:0]  prev_cell;

  // input register
  logic              s1_valid;
  logic [VOL_W-1:0]  s1_cur;
  logic              s1_xgt0;
  logic              s1_use_row;
  logic              s1_use_plane;
  logic [1:0]        s1_shift;
  logic              s1_zero;
  logic              s1_last;
  logic [ADDR_W-1:0] s1_addr;

  // effective geometry
  logic              dim2, dim3;
  logic [SIZE_W-1:0] nx, ny, nz;
  always_comb begin
    dim2 = (num_dims == 2'd2) || (num_dims == 2'd3);
    dim3 = (num_dims == 2'd3);
    nx   = clamp_size(size_x, SIZE_W'(MAX_X));
    ny   = dim2 ? clamp_size(size_y, SIZE_W'(MAX_Y)) : SIZE_W'(1);
    nz   = dim3 ? clamp_size(size_z, SIZE_W'(MAX_Z)) : SIZE_W'(1);
  end

  // handshake
  logic accept, adv;
  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;
  assign accept   = in_valid && !in_stall;

  // position-derived flags of the incoming beat
  logic       x_more, y_more, z_more;
  logic       x_gt0, y_gt0, z_gt0;
  logic       cell_ok;
  logic       cx2, cy2, cz2, cx0, cy0, cz0;
  logic [1:0] shift_next;
  always_comb begin
    x_more     = ({1'b0, x_pos} + SIZE_W'(1)) < nx;
    y_more     = (SIZE_W'(y_pos) + SIZE_W'(1)) < ny;
    z_more     = (SIZE_W'(z_pos) + SIZE_W'(1)) < nz;
    x_gt0      = (x_pos != '0);
    y_gt0      = (y_pos != '0);
    z_gt0      = (z_pos != '0);
    cell_ok    = x_more && (!dim2 || y_more) && (!dim3 || z_more);
    cx2        = x_gt0 && x_more;
    cx0        = !x_gt0 && !x_more;
    cy2        = dim2 && y_gt0 && y_more;
    cy0        = dim2 && !y_gt0 && !y_more;
    cz2        = dim3 && z_gt0 && z_more;
    cz0        = dim3 && !z_gt0 && !z_more;
    shift_next = 2'(cx2) + 2'(cy2) + 2'(cz2);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims <= NUM_DIMS_RST;
      size_x   <= SIZE_X_RST;
      size_y   <= SIZE_Y_RST;
      size_z   <= SIZE_Z_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NUM_DIMS: num_dims <= cfg_data[1:0];
        REG_SIZE_X:   size_x   <= cfg_data;
        REG_SIZE_Y:   size_y   <= cfg_data;
        REG_SIZE_Z:   size_z   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // raster position, restarted by any configuration write
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      x_pos <= '0;
      y_pos <= '0;
      z_pos <= '0;
    end else if (accept) begin
      if (!x_more) begin
        x_pos <= '0;
        if (!y_more) begin
          y_pos <= '0;
          z_pos <= z_more ? z_pos + Z_W'(1) : '0;
        end else begin
          y_pos <= y_pos + Y_W'(1);
        end
      end else begin
        x_pos <= x_pos + X_W'(1);
      end
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  // input register payload and buffer reads
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur       <= cell_ok ? cell_volume : '0;
      s1_xgt0      <= x_gt0;
      s1_use_row   <= dim2 && y_gt0;
      s1_use_plane <= dim3 && z_gt0;
      s1_shift     <= shift_next;
      s1_zero      <= cx0 || cy0 || cz0;
      s1_last      <= !x_more && !y_more && !z_more;
      s1_addr      <= {y_pos, x_pos};
      row_rd       <= row_mem[x_pos];
      plane_rd     <= plane_mem[{y_pos, x_pos}];
    end
  end

  // box sum: x pair, then y quad, then z octet
  logic [PAIR_W-1:0] xs;
  logic [QUAD_W-1:0] ys;
  logic [OCT_W-1:0]  zs;
  logic [OCT_W-1:0]  zs_shifted;
  always_comb begin
    xs         = PAIR_W'(s1_cur) + (s1_xgt0 ? PAIR_W'(prev_cell) : '0);
    ys         = QUAD_W'(xs) + (s1_use_row ? QUAD_W'(row_rd) : '0);
    zs         = OCT_W'(ys) + (s1_use_plane ? OCT_W'(plane_rd) : '0);
    zs_shifted = zs >> s1_shift;
  end

  // buffer writes and previous cell as the item leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cell <= '0;
    end else if (adv) begin
      prev_cell <= s1_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_mem[s1_addr[X_W-1:0]] <= xs;
      plane_mem[s1_addr]        <= ys;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      point_volume <= s1_zero ? '0 : zs_shifted[VOL_W-1:0];
      end_of_grid  <= s1_last;
    end
  end

  // a configuration write restarts the raster
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (x_pos == '0) && (y_pos == '0) && (z_pos == '0))
    else $error("position not restarted after configuration write");

  // position stays inside the active grid
  a_pos_in_grid: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, x_pos} < nx) && (SIZE_W'(y_pos) < ny) && (SIZE_W'(z_pos) < nz))
    else $error("grid position outside active grid");

  // the input side is held only by an occupied input register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // a held input register keeps its buffer address
  a_hold_addr: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv && !cfg_write) |=> $stable(s1_addr))
    else $error("input register changed while held");

endmodule

// ===== sim/cnva_checker.sv =====
// beat monitor, volume-average predictor and result comparison for the averaging block
module cnva_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [cnva_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cnva_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [cnva_pkg::VOL_W-1:0]      cell_volume,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [cnva_pkg::VOL_W-1:0]      point_volume,
  input  logic                            end_of_grid,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cnva_pkg::*;

  // keeps the log short when the stream falls out of step
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [VOL_W-1:0] volume;
    logic             last;
  } point_t;

  point_t expected_points[$];

  // mirrored registers
  logic [1:0]        dims_reg;
  logic [SIZE_W-1:0] size_x_reg;
  logic [SIZE_W-1:0] size_y_reg;
  logic [SIZE_W-1:0] size_z_reg;

  // mirrored sum buffers and grid position
  logic [VOL_W-1:0]  prev_cell;
  logic [PAIR_W-1:0] row_pairs [MAX_X];
  logic [QUAD_W-1:0] plane_quads [MAX_X*MAX_Y];
  int unsigned       x_at;
  int unsigned       y_at;
  int unsigned       z_at;

  // size register as the grid sees it
  function automatic int unsigned fit_size(logic [SIZE_W-1:0] s, int unsigned maxv);
    if (s == '0) return 1;
    if (s > maxv) return maxv;
    return 32'(s);
  endfunction

  // existing cells among p-1 and p along one dimension
  function automatic int unsigned cells_around(int unsigned p, int unsigned n);
    return (p > 0 ? 1 : 0) + (p + 1 < n ? 1 : 0);
  endfunction

  task automatic average_next_point(input logic [VOL_W-1:0] vol);
    int unsigned       nd;
    int unsigned       nx;
    int unsigned       ny;
    int unsigned       nz;
    int unsigned       i;
    int unsigned       j;
    int unsigned       k;
    int unsigned       pidx;
    int unsigned       count;
    logic              live;
    logic [VOL_W-1:0]  cur;
    logic [PAIR_W-1:0] xs;
    logic [QUAD_W-1:0] ys;
    logic [OCT_W-1:0]  zs;
    point_t            p;
    nd = (dims_reg == 2'd0) ? 1 : 32'(dims_reg);
    nx = fit_size(size_x_reg, MAX_X);
    ny = (nd >= 2) ? fit_size(size_y_reg, MAX_Y) : 1;
    nz = (nd >= 3) ? fit_size(size_z_reg, MAX_Z) : 1;
    i = x_at;
    j = y_at;
    k = z_at;
    pidx = j * MAX_X + i;

    // cell past the last one in an active dimension contributes nothing
    live = (i + 1 < nx) && (nd < 2 || j + 1 < ny) && (nd < 3 || k + 1 < nz);
    cur = live ? vol : '0;

    // x pair, then row, then plane accumulation
    xs = PAIR_W'(cur) + ((i > 0) ? PAIR_W'(prev_cell) : PAIR_W'(0));
    prev_cell = cur;
    ys = QUAD_W'(xs);
    if (nd >= 2 && j > 0) ys += QUAD_W'(row_pairs[i]);
    row_pairs[i] = xs;
    zs = OCT_W'(ys);
    if (nd >= 3 && k > 0) zs += OCT_W'(plane_quads[pidx]);
    plane_quads[pidx] = ys;

    // cell count is a power of two, so the average is a shift
    count = cells_around(i, nx);
    if (nd >= 2) count *= cells_around(j, ny);
    if (nd >= 3) count *= cells_around(k, nz);
    p.volume = (count == 0) ? '0 : VOL_W'(zs >> $clog2(count));
    p.last = (i + 1 >= nx) && (j + 1 >= ny) && (k + 1 >= nz);
    expected_points.push_back(p);

    // raster step, x fastest
    if (i + 1 >= nx) begin
      i = 0;
      if (j + 1 >= ny) begin
        j = 0;
        k = (k + 1 >= nz) ? 0 : k + 1;
      end else begin
        j++;
      end
    end else begin
      i++;
    end
    x_at = i;
    y_at = j;
    z_at = k;
  endtask

  task automatic note_failure(input string what, input logic [VOL_W-1:0] want,
                              input logic [VOL_W-1:0] got);
    if (fail_count < REPORT_CAP)
      $display("%0t ns: %s expected %h actual %h", $time, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      dims_reg = NUM_DIMS_RST;
      size_x_reg = SIZE_X_RST;
      size_y_reg = SIZE_Y_RST;
      size_z_reg = SIZE_Z_RST;
      prev_cell = '0;
      x_at = 0;
      y_at = 0;
      z_at = 0;
      fail_count = 0;
      expected_points.delete();
    end else begin
      // register write, grid restarts
      if (cfg_write) begin
        case (cfg_index)
          REG_NUM_DIMS: dims_reg = cfg_data[1:0];
          REG_SIZE_X:   size_x_reg = cfg_data;
          REG_SIZE_Y:   size_y_reg = cfg_data;
          REG_SIZE_Z:   size_z_reg = cfg_data;
        endcase
        x_at = 0;
        y_at = 0;
        z_at = 0;
      end

      // input beat
      if (in_valid && !in_stall) average_next_point(cell_volume);

      // output beat against oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          note_failure("unexpected point_volume", '0, point_volume);
        end else begin
          want = expected_points.pop_front();
          if (point_volume !== want.volume)
            note_failure("point_volume", want.volume, point_volume);
          if (end_of_grid !== want.last)
            note_failure("end_of_grid", VOL_W'(want.last), VOL_W'(end_of_grid));
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

// ===== sim/cell_to_node_volume_average_tb.sv =====
// stimulus, handshake idling and verdict for the cell-to-node volume averaging block
module cell_to_node_volume_average_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cnva_pkg::*;

  localparam int NUM_ITEMS      = 1000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [VOL_W-1:0]      cell_volume = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VOL_W-1:0]      point_volume;
  logic                  end_of_grid;

  int fail_count;
  int pending;
  int send_idle_pct = 18;
  int stall_pct = 49;
  int sent_points = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  cell_to_node_volume_average u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cell_volume  (cell_volume),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_volume (point_volume),
    .end_of_grid  (end_of_grid)
  );

  cnva_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cell_volume  (cell_volume),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_volume (point_volume),
    .end_of_grid  (end_of_grid),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // mostly random, with the extremes now and then
  function automatic logic [VOL_W-1:0] rand_volume();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return VOL_W'($urandom_range(255));
      default: return VOL_W'($urandom);
    endcase
  endfunction

  // small sizes mostly, rare degenerate and oversize values
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(23))
      0: return SIZE_W'(0);
      1: return SIZE_W'(1);
      2: return SIZE_W'(256);
      3: return SIZE_W'(511);
      4: return SIZE_W'($urandom_range(511));
      default: return SIZE_W'($urandom_range(5, 2));
    endcase
  endfunction

  function automatic int unsigned grid_points(logic [1:0] nd, logic [SIZE_W-1:0] sx,
                                              logic [SIZE_W-1:0] sy, logic [SIZE_W-1:0] sz);
    int unsigned d;
    int unsigned px;
    int unsigned py;
    int unsigned pz;
    d = (nd == 2'd0) ? 1 : 32'(nd);
    px = (sx == '0) ? 1 : ((sx > MAX_X) ? MAX_X : 32'(sx));
    py = (d < 2 || sy == '0) ? 1 : ((sy > MAX_Y) ? MAX_Y : 32'(sy));
    pz = (d < 3 || sz == '0) ? 1 : ((sz > MAX_Z) ? MAX_Z : 32'(sz));
    return px * py * pz;
  endfunction

  // one input beat, entered and left at a falling edge; valid stays up afterwards
  task automatic send_cell(input logic [VOL_W-1:0] vol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cell_volume <= vol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_points++;
    @(negedge clk);
  endtask

  task automatic send_random_cells(input int unsigned n);
    repeat (n) send_cell(rand_volume());
  endtask

  // stop sending and wait for every expected point
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // write all four registers on back-to-back cycles
  task automatic apply_grid(input logic [1:0] nd, input logic [SIZE_W-1:0] sx,
                            input logic [SIZE_W-1:0] sy, input logic [SIZE_W-1:0] sz);
    cfg_write <= 1'b1;
    cfg_index <= REG_NUM_DIMS;
    cfg_data <= {7'($urandom_range(127)), nd};
    @(negedge clk);
    cfg_index <= REG_SIZE_X;
    cfg_data <= sx;
    @(negedge clk);
    cfg_index <= REG_SIZE_Y;
    cfg_data <= sy;
    @(negedge clk);
    cfg_index <= REG_SIZE_Z;
    cfg_data <= sz;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [1:0]        nd;
    logic [SIZE_W-1:0] sx;
    logic [SIZE_W-1:0] sy;
    logic [SIZE_W-1:0] sz;
    int unsigned       pts;
    int unsigned       n;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default grid, full-scale and zero volumes
    send_cell('1);
    send_cell('0);
    drain();

    // zero dimensions behaves as one; the pair sum carries past 32 bits
    apply_grid(2'd0, SIZE_W'(3), SIZE_W'(0), SIZE_W'(0));
    send_cell('1);
    send_cell('1);
    send_cell(32'h1234_5678);
    drain();

    // single point along x, no neighbouring cell
    apply_grid(2'd1, SIZE_W'(0), SIZE_W'(5), SIZE_W'(5));
    send_random_cells(2);
    drain();

    // single point along an active y
    apply_grid(2'd2, SIZE_W'(2), SIZE_W'(1), SIZE_W'(9));
    send_random_cells(2);
    drain();

    // oversize z clamps; two planes of full-scale cells, then restart mid-grid
    apply_grid(2'd3, SIZE_W'(2), SIZE_W'(2), SIZE_W'(511));
    repeat (8) send_cell('1);
    drain();

    // zero z size taken as one point
    apply_grid(2'd3, SIZE_W'(2), SIZE_W'(2), SIZE_W'(0));
    send_random_cells(4);
    drain();

    // oversize x clamps
    apply_grid(2'd1, SIZE_W'(511), SIZE_W'(0), SIZE_W'(0));
    send_random_cells(4);
    drain();

    // random grids, mostly whole passes, large ones cut short
    while (sent_points < NUM_ITEMS) begin
      if (sent_points < NUM_ITEMS / 3) begin
        send_idle_pct = 18;
        stall_pct = 49;
      end else if (sent_points < 2 * NUM_ITEMS / 3) begin
        send_idle_pct = 49;
        stall_pct = 18;
      end else begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      nd = 2'($urandom_range(3));
      sx = pick_size();
      sy = pick_size();
      sz = pick_size();
      apply_grid(nd, sx, sy, sz);
      pts = grid_points(nd, sx, sy, sz);
      if (pts > 128) n = $urandom_range(96, 16);
      else if ($urandom_range(7) == 0) n = $urandom_range(2 * pts, 1);
      else n = pts * $urandom_range(2, 1);
      send_random_cells(n);
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
